// ===== rtl/core/mcr_pkg.sv =====
`default_nettype none

package mcr_pkg;

  localparam int unsigned CHANNELS            = 16;
  localparam int unsigned EVENT_DEPTH_DEFAULT = 128;
  localparam int unsigned CONTROLLERS_DEFAULT = 128;
  localparam int unsigned PENDING_W           = 7;

  localparam logic [7:0] LIMIT_RESET  = 8'd127;
  localparam logic [7:0] STATUS_MASK  = 8'hf0;
  localparam logic [7:0] CHANNEL_MASK = 8'h0f;
  localparam logic [7:0] KIND_CONTROL = 8'hb0;
  localparam logic [7:0] KIND_NOTE_OFF = 8'h80;
  localparam logic [7:0] KIND_NOTE_ON  = 8'h90;
  localparam logic [8:0] CTRL_ABSENT  = 9'h1ff;

  typedef enum logic [1:0] {
    CMD_RECEIVE    = 2'd0,
    CMD_POP        = 2'd1,
    CMD_READ_FLAG  = 2'd2,
    CMD_READ_VALUE = 2'd3
  } cmd_e;

  // A completed three-byte message, valid for one accepted transaction.
  typedef struct packed {
    logic       ctrl;
    logic       note;
    logic [7:0] status;
    logic [7:0] first;
    logic [7:0] source;
    logic [7:0] second;
  } msg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] source;
    logic [7:0] status;
    logic [7:0] first;
    logic [7:0] second;
  } event_t;

  typedef struct packed {
    logic                 empty;
    logic [PENDING_W-1:0] pending;
  } q_stat_t;

  typedef struct packed {
    logic       present;
    logic       changed;
    logic [7:0] value;
  } tbl_rd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mcr_ram.sv =====
`default_nettype none

module mcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and a write of the same entry at one edge return the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/mcr_parser.sv =====
`default_nettype none

module mcr_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rcv_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [7:0]  source_id_i,
  output mcr_pkg::msg_t    msg_o
);

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_FIRST,
    PH_SECOND
  } phase_e;

  phase_e     phase_q;
  logic [7:0] held_status_q;
  logic [7:0] held_first_q;
  logic [7:0] held_source_q;
  logic [7:0] kind;
  logic       opens;
  logic       finish;

  assign kind   = rx_byte_i & mcr_pkg::STATUS_MASK;
  assign opens  = (kind == mcr_pkg::KIND_CONTROL) || (kind == mcr_pkg::KIND_NOTE_OFF) ||
                  (kind == mcr_pkg::KIND_NOTE_ON);
  assign finish = rcv_i && (phase_q == PH_SECOND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_STATUS;
      held_status_q <= '0;
      held_first_q  <= '0;
      held_source_q <= '0;
    end else if (rcv_i) begin
      unique case (phase_q)
        PH_STATUS: begin
          if (opens) begin
            held_status_q <= rx_byte_i;
            held_source_q <= source_id_i;
            phase_q       <= PH_FIRST;
          end
        end
        PH_FIRST: begin
          held_first_q <= rx_byte_i;
          phase_q      <= PH_SECOND;
        end
        default: begin
          phase_q <= PH_STATUS;
        end
      endcase
    end
  end

  always_comb begin
    msg_o.ctrl   = finish &&
                   ((held_status_q & mcr_pkg::STATUS_MASK) == mcr_pkg::KIND_CONTROL);
    msg_o.note   = finish &&
                   ((held_status_q & mcr_pkg::STATUS_MASK) != mcr_pkg::KIND_CONTROL);
    msg_o.status = held_status_q;
    msg_o.first  = held_first_q;
    msg_o.source = held_source_q;
    msg_o.second = rx_byte_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcr_event_queue.sv =====
`default_nettype none

module mcr_event_queue #(
  parameter int unsigned EVENT_DEPTH = mcr_pkg::EVENT_DEPTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_i,
  input  wire mcr_pkg::msg_t msg_i,
  output mcr_pkg::event_t  ev_o,
  output mcr_pkg::q_stat_t stat_o
);

  localparam int unsigned PW = $clog2(EVENT_DEPTH);
  localparam int unsigned CW = (PW > mcr_pkg::PENDING_W) ? PW : mcr_pkg::PENDING_W;

  logic [PW-1:0] wp_q;
  logic [PW-1:0] rp_q;
  logic [PW-1:0] wp_next;
  logic [PW-1:0] rp_next;
  logic          empty;
  logic          push_ok;
  logic          pop_ok;
  logic          pop_ok_q;
  logic [31:0]   wdata;
  logic [31:0]   rdata;
  logic [PW:0]   diff;
  logic [CW-1:0] count;

  assign wp_next = (wp_q == PW'(EVENT_DEPTH - 1)) ? '0 : wp_q + PW'(1);
  assign rp_next = (rp_q == PW'(EVENT_DEPTH - 1)) ? '0 : rp_q + PW'(1);
  assign empty   = (wp_q == rp_q);
  assign push_ok = msg_i.note && (wp_next != rp_q);
  assign pop_ok  = pop_i && !empty;
  assign wdata   = {msg_i.source, msg_i.status, msg_i.first, msg_i.second};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      pop_ok_q <= 1'b0;
    end else begin
      if (push_ok) begin
        wp_q <= wp_next;
      end
      if (pop_ok) begin
        rp_q <= rp_next;
      end
      if (pop_i) begin
        pop_ok_q <= pop_ok;
      end
    end
  end

  mcr_ram #(
    .WIDTH (32),
    .DEPTH (EVENT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .re_i    (pop_ok),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_comb begin
    diff = {1'b0, wp_q} - {1'b0, rp_q};
    if (wp_q < rp_q) begin
      diff = diff + (PW + 1)'(EVENT_DEPTH);
    end
    count = CW'(diff[PW-1:0]);
  end

  always_comb begin
    ev_o.valid  = pop_ok_q;
    ev_o.source = pop_ok_q ? rdata[31:24] : '0;
    ev_o.status = pop_ok_q ? rdata[23:16] : '0;
    ev_o.first  = pop_ok_q ? rdata[15:8]  : '0;
    ev_o.second = pop_ok_q ? rdata[7:0]   : '0;
    stat_o.empty   = empty;
    stat_o.pending = count[mcr_pkg::PENDING_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mcr_ctrl_table.sv =====
`default_nettype none

module mcr_ctrl_table #(
  parameter int unsigned CONTROLLERS = mcr_pkg::CONTROLLERS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        query_i,
  input  wire logic        clear_flag_i,
  input  wire logic [3:0]  query_channel_i,
  input  wire logic [6:0]  query_controller_i,
  input  wire logic [7:0]  limit_i,
  input  wire mcr_pkg::msg_t msg_i,
  output logic             busy_o,
  output mcr_pkg::tbl_rd_t rd_o
);

  localparam int unsigned TD = mcr_pkg::CHANNELS * CONTROLLERS;
  localparam int unsigned AW = $clog2(TD);
  localparam int unsigned MW = AW + 8;

  logic          clr_active_q;
  logic [AW-1:0] clr_cnt_q;
  logic [MW-1:0] wsum;
  logic [MW-1:0] qsum;
  logic [AW-1:0] widx;
  logic [AW-1:0] qidx;
  logic          w_in_range;
  logic          q_present;
  logic          present_q;
  logic          ctrl_wr;
  logic          val_we;
  logic [AW-1:0] val_waddr;
  logic [7:0]    val_wdata;
  logic          flg_we;
  logic [AW-1:0] flg_waddr;
  logic          flg_wdata;
  logic [7:0]    val_rdata;
  logic          flg_rdata;

  assign wsum = MW'(msg_i.status & mcr_pkg::CHANNEL_MASK) * MW'(CONTROLLERS) + MW'(msg_i.first);
  assign qsum = MW'(query_channel_i) * MW'(CONTROLLERS) + MW'(query_controller_i);
  assign widx = wsum[AW-1:0];
  assign qidx = qsum[AW-1:0];

  assign w_in_range = (msg_i.first < limit_i) && (msg_i.first < 8'(CONTROLLERS));
  assign q_present  = ({1'b0, query_controller_i} < limit_i) &&
                      ({1'b0, query_controller_i} < 8'(CONTROLLERS));
  assign ctrl_wr    = msg_i.ctrl && w_in_range;

  // After reset both tables are swept to zero, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      present_q    <= 1'b0;
    end else begin
      if (clr_active_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(TD - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (query_i) begin
        present_q <= q_present;
      end
    end
  end

  always_comb begin
    val_we    = clr_active_q || ctrl_wr;
    val_waddr = clr_active_q ? clr_cnt_q : widx;
    val_wdata = clr_active_q ? 8'd0 : msg_i.second;
    flg_we    = 1'b0;
    flg_waddr = qidx;
    flg_wdata = 1'b0;
    if (clr_active_q) begin
      flg_we    = 1'b1;
      flg_waddr = clr_cnt_q;
    end else if (ctrl_wr) begin
      flg_we    = 1'b1;
      flg_waddr = widx;
      flg_wdata = 1'b1;
    end else if (clear_flag_i && q_present) begin
      flg_we = 1'b1;
    end
  end

  mcr_ram #(
    .WIDTH (8),
    .DEPTH (TD)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (query_i),
    .raddr_i (qidx),
    .rdata_o (val_rdata)
  );

  mcr_ram #(
    .WIDTH (1),
    .DEPTH (TD)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (flg_we),
    .waddr_i (flg_waddr),
    .wdata_i (flg_wdata),
    .re_i    (query_i),
    .raddr_i (qidx),
    .rdata_o (flg_rdata)
  );

  assign busy_o = clr_active_q;

  always_comb begin
    rd_o.present = present_q;
    rd_o.changed = flg_rdata;
    rd_o.value   = val_rdata;
  end

endmodule

`default_nettype wire

// ===== rtl/core/midi_control_receiver.sv =====
// Table and event reads of an accepted transaction are registered into the result stage; the
// result is loaded into the output register when that stage advances, which out_stall_i can
// hold off. Throughput: one transaction per cycle while in_stall_o is low. Reset: asynchronous,
// active low. Afterwards the controller table, 16 * CONTROLLERS entries (2048 by default),
// is swept to zero with the input stalled; config writes are taken.
`default_nettype none

module midi_control_receiver #(
  parameter int unsigned EVENT_DEPTH = mcr_pkg::EVENT_DEPTH_DEFAULT,
  parameter int unsigned CONTROLLERS = mcr_pkg::CONTROLLERS_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [7:0]        source_id_i,
  input  wire logic [3:0]        query_channel_i,
  input  wire logic [6:0]        query_controller_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   event_valid_o,
  output logic [7:0]             event_source_o,
  output logic [7:0]             event_status_o,
  output logic [7:0]             event_first_o,
  output logic [7:0]             event_second_o,
  output logic                   ctrl_changed_o,
  output logic signed [8:0]      ctrl_value_o,
  output logic [6:0]             pending_events_o
);

  logic [7:0]            limit_q;
  logic                  accept;
  logic                  busy;
  logic                  s1_valid_q;
  mcr_pkg::cmd_e         s1_cmd_q;
  logic                  s1_adv;
  mcr_pkg::msg_t         msg;
  mcr_pkg::event_t       ev;
  mcr_pkg::q_stat_t      q_stat;
  mcr_pkg::tbl_rd_t      tbl_rd;
  logic                  out_valid_q;
  mcr_pkg::event_t       out_ev_q;
  logic                  out_changed_q;
  logic [8:0]            out_value_q;
  logic [6:0]            out_pending_q;
  mcr_pkg::event_t       res_ev;
  logic                  res_changed;
  logic [8:0]            res_value;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy || (s1_valid_q && !s1_adv);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mcr_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  mcr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rcv_i       (accept && (command_i == mcr_pkg::CMD_RECEIVE)),
    .rx_byte_i   (rx_byte_i),
    .source_id_i (source_id_i),
    .msg_o       (msg)
  );

  mcr_event_queue #(
    .EVENT_DEPTH (EVENT_DEPTH)
  ) u_events (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pop_i  (accept && (command_i == mcr_pkg::CMD_POP)),
    .msg_i  (msg),
    .ev_o   (ev),
    .stat_o (q_stat)
  );

  mcr_ctrl_table #(
    .CONTROLLERS (CONTROLLERS)
  ) u_table (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .query_i            (accept && ((command_i == mcr_pkg::CMD_READ_FLAG) ||
                                    (command_i == mcr_pkg::CMD_READ_VALUE))),
    .clear_flag_i       (accept && (command_i == mcr_pkg::CMD_READ_FLAG)),
    .query_channel_i    (query_channel_i),
    .query_controller_i (query_controller_i),
    .limit_i            (limit_q),
    .msg_i              (msg),
    .busy_o             (busy),
    .rd_o               (tbl_rd)
  );

  always_comb begin
    res_ev      = '0;
    res_changed = 1'b0;
    res_value   = '0;
    case (s1_cmd_q)
      mcr_pkg::CMD_POP: begin
        res_ev = ev;
      end
      mcr_pkg::CMD_READ_FLAG: begin
        res_changed = tbl_rd.present && tbl_rd.changed;
      end
      mcr_pkg::CMD_READ_VALUE: begin
        res_value = tbl_rd.present ? {1'b0, tbl_rd.value} : mcr_pkg::CTRL_ABSENT;
      end
      default: begin
        res_ev = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_cmd_q    <= mcr_pkg::CMD_RECEIVE;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_cmd_q   <= mcr_pkg::cmd_e'(command_i);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ev_q      <= res_ev;
      out_changed_q <= res_changed;
      out_value_q   <= res_value;
      out_pending_q <= q_stat.pending;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_valid_o    = out_ev_q.valid;
  assign event_source_o   = out_ev_q.source;
  assign event_status_o   = out_ev_q.status;
  assign event_first_o    = out_ev_q.first;
  assign event_second_o   = out_ev_q.second;
  assign ctrl_changed_o   = out_changed_q;
  assign ctrl_value_o     = $signed(out_value_q);
  assign pending_events_o = out_pending_q;

  a_s1_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction did not reach the result stage");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy)
    else $error("table clearing restarted outside reset");

  a_value_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ctrl_value_o[8]) |-> (out_value_q == mcr_pkg::CTRL_ABSENT))
    else $error("negative controller value other than absent");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == mcr_pkg::CMD_POP) && !q_stat.empty) |=>
      (q_stat.pending == 7'($past(q_stat.pending) - 7'd1)))
    else $error("pop of a queued event did not reduce the pending count");

endmodule

`default_nettype wire
